[src/lpdd_pkg.sv]
// Package for the length-prefixed datagram deframer.
// Holds field lengths, phase and result-kind codes and the result struct.
// No dependencies.
package lpdd_pkg;

    // Field lengths in bytes
    localparam logic [31:0] START_BYTES      = 32'd2;
    localparam logic [31:0] TYPE_BYTES       = 32'd1;
    localparam logic [31:0] ID_BYTES         = 32'd8;
    localparam logic [31:0] REQUEST_ID_BYTES = 32'd68;
    localparam logic [31:0] STAMP_BYTES      = 32'd8;
    localparam logic [31:0] LEN_BYTES        = 32'd4;
    localparam logic [31:0] PREFIX_BYTES     = 32'd4;
    localparam logic [31:0] END_BYTES        = 32'd2;

    // Field currently being received
    typedef enum logic [3:0] {
        PH_START  = 4'd0,
        PH_TYPE   = 4'd1,
        PH_ID     = 4'd2,
        PH_REQID  = 4'd3,
        PH_STAMP  = 4'd4,
        PH_LEN    = 4'd5,
        PH_PREFIX = 4'd6,
        PH_BODY   = 4'd7,
        PH_END    = 4'd8
    } t_phase;

    // Result kinds
    typedef enum logic [1:0] {
        KIND_REQID = 2'd0,
        KIND_BODY  = 2'd1,
        KIND_FRAME = 2'd2
    } t_kind;

    // One result request
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  data_byte;
        logic        last_body_byte;
        logic [15:0] start_mark;
        logic [7:0]  message_type;
        logic [63:0] frame_id;
        logic [63:0] time_stamp;
        logic [31:0] body_length;
        logic [15:0] end_mark;
    } t_result;

endpackage

[src/lpdd_parser.sv]
// Byte parser: phase/count tracking and header field shift registers.
// Depends on lpdd_pkg; produces at most one result per accepted byte.
module lpdd_parser import lpdd_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_accept,
    input  logic [7:0] i_rx_byte,
    output logic       o_res_valid,
    output t_result    o_res
);

    t_phase      r_phase, n_phase;
    logic [31:0] r_count, n_count;
    logic [15:0] r_start, n_start;
    logic [7:0]  r_type, n_type;
    logic [63:0] r_id, n_id;
    logic [63:0] r_stamp, n_stamp;
    logic [31:0] r_len, n_len;
    logic [15:0] r_end, n_end;

    logic [31:0] w_inc;
    logic        w_last;

    assign w_inc  = r_count + 32'd1;
    assign w_last = (r_count == (r_len - 32'd1));

    // Next state and result for the byte on the input
    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_start     = r_start;
        n_type      = r_type;
        n_id        = r_id;
        n_stamp     = r_stamp;
        n_len       = r_len;
        n_end       = r_end;
        o_res_valid = 1'b0;
        o_res       = '0;
        unique case (r_phase)
            PH_TYPE: begin
                n_type = i_rx_byte;
                if (w_inc >= TYPE_BYTES) begin
                    n_count = '0;
                    n_phase = PH_ID;
                end else begin
                    n_count = w_inc;
                end
            end
            PH_ID: begin
                n_id = {r_id[55:0], i_rx_byte};
                if (w_inc >= ID_BYTES) begin
                    n_count = '0;
                    n_phase = PH_REQID;
                end else begin
                    n_count = w_inc;
                end
            end
            PH_REQID: begin
                o_res_valid     = 1'b1;
                o_res.kind      = KIND_REQID;
                o_res.data_byte = i_rx_byte;
                if (w_inc >= REQUEST_ID_BYTES) begin
                    n_count = '0;
                    n_phase = PH_STAMP;
                end else begin
                    n_count = w_inc;
                end
            end
            PH_STAMP: begin
                n_stamp = {r_stamp[55:0], i_rx_byte};
                if (w_inc >= STAMP_BYTES) begin
                    n_count = '0;
                    n_phase = PH_LEN;
                end else begin
                    n_count = w_inc;
                end
            end
            PH_LEN: begin
                n_len = {r_len[23:0], i_rx_byte};
                if (w_inc >= LEN_BYTES) begin
                    n_count = '0;
                    n_phase = PH_PREFIX;
                end else begin
                    n_count = w_inc;
                end
            end
            PH_PREFIX: begin
                // empty body skips straight to the end mark
                if (w_inc >= PREFIX_BYTES) begin
                    n_count = '0;
                    n_phase = (r_len == '0) ? PH_END : PH_BODY;
                end else begin
                    n_count = w_inc;
                end
            end
            PH_BODY: begin
                o_res_valid          = 1'b1;
                o_res.kind           = KIND_BODY;
                o_res.data_byte      = i_rx_byte;
                o_res.last_body_byte = w_last;
                if (w_last) begin
                    n_count = '0;
                    n_phase = PH_END;
                end else begin
                    n_count = w_inc;
                end
            end
            PH_END: begin
                n_end = {r_end[7:0], i_rx_byte};
                if (w_inc < END_BYTES) begin
                    n_count = w_inc;
                end else begin
                    n_count            = '0;
                    n_phase            = PH_START;
                    o_res_valid        = 1'b1;
                    o_res.kind         = KIND_FRAME;
                    o_res.start_mark   = r_start;
                    o_res.message_type = r_type;
                    o_res.frame_id     = r_id;
                    o_res.time_stamp   = r_stamp;
                    o_res.body_length  = r_len;
                    o_res.end_mark     = {r_end[7:0], i_rx_byte};
                end
            end
            default: begin
                // start mark; unused codes restart with an empty count
                n_start = {r_start[7:0], i_rx_byte};
                if (((r_phase == PH_START) ? w_inc : 32'd1) >= START_BYTES) begin
                    n_count = '0;
                    n_phase = PH_TYPE;
                end else begin
                    n_count = (r_phase == PH_START) ? w_inc : 32'd1;
                    n_phase = PH_START;
                end
            end
        endcase
        if (!i_accept) begin
            o_res_valid = 1'b0;
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_START;
            r_count <= '0;
        end else if (i_accept) begin
            r_phase <= n_phase;
            r_count <= n_count;
        end
    end

    // Header shift registers, fully reloaded each frame
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start <= '0;
            r_type  <= '0;
            r_id    <= '0;
            r_stamp <= '0;
            r_len   <= '0;
            r_end   <= '0;
        end else if (i_accept) begin
            r_start <= n_start;
            r_type  <= n_type;
            r_id    <= n_id;
            r_stamp <= n_stamp;
            r_len   <= n_len;
            r_end   <= n_end;
        end
    end

endmodule

[src/lpdd_out_buf.sv]
// Result register with one skid entry.
// Depends on lpdd_pkg; stalls upstream only when the skid entry is full.
module lpdd_out_buf import lpdd_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_push,
    input  t_result i_res,
    output logic    o_full,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_res
);

    logic    r_main_v, r_skid_v;
    t_result r_main, r_skid;
    logic    w_free;

    // main slot can load when empty or being taken this cycle
    assign w_free = !r_main_v || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_main_v <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (w_free) begin
            if (r_skid_v) begin
                r_main_v <= 1'b1;
                r_skid_v <= 1'b0;
            end else begin
                r_main_v <= i_push;
            end
        end else if (i_push) begin
            r_skid_v <= 1'b1;
        end
    end

    // Payload
    always_ff @(posedge i_clk) begin
        if (w_free) begin
            r_main <= r_skid_v ? r_skid : i_res;
        end else if (i_push) begin
            r_skid <= i_res;
        end
    end

    assign o_full  = r_skid_v;
    assign o_valid = r_main_v;
    assign o_res   = r_main;

endmodule

[src/length_prefixed_datagram_deframer_core.sv]
// Top level of the length-prefixed datagram deframer.
// Depends on lpdd_pkg, lpdd_parser and lpdd_out_buf.
//
//  channel  | valid        | stall        | payload
//  ---------+--------------+--------------+-------------------------------------
//  input    | i_in_valid   | o_in_stall   | i_rx_byte
//  result   | o_out_valid  | i_out_stall  | o_kind .. o_end_mark
//
// The parser is a single pass over phase and count registers, so it accepts one
// byte per cycle with no bubbles while o_in_stall is low; its result, if any, is
// registered in the result register, or in the skid entry while that is stalled.
// Synchronous active-low reset returns to the start mark phase, outputs empty.
// A one-entry skid behind the result register keeps input flowing while a
// result waits; input stalls only once that skid entry is also occupied.
module length_prefixed_datagram_deframer_core import lpdd_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [1:0]  o_kind,
    output logic [7:0]  o_data_byte,
    output logic        o_last_body_byte,
    output logic [15:0] o_start_mark,
    output logic [7:0]  o_message_type,
    output logic [63:0] o_frame_id,
    output logic [63:0] o_time_stamp,
    output logic [31:0] o_body_length,
    output logic [15:0] o_end_mark
);

    logic    w_full, w_accept, w_res_valid;
    t_result w_res, w_out;

    assign w_accept   = i_in_valid && !w_full;
    assign o_in_stall = w_full;

    // Byte parser
    lpdd_parser u_parser (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (w_accept),
        .i_rx_byte   (i_rx_byte),
        .o_res_valid (w_res_valid),
        .o_res       (w_res)
    );

    // Result register and skid
    lpdd_out_buf u_out_buf (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_res_valid),
        .i_res   (w_res),
        .o_full  (w_full),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_res   (w_out)
    );

    assign o_kind           = w_out.kind;
    assign o_data_byte      = w_out.data_byte;
    assign o_last_body_byte = w_out.last_body_byte;
    assign o_start_mark     = w_out.start_mark;
    assign o_message_type   = w_out.message_type;
    assign o_frame_id       = w_out.frame_id;
    assign o_time_stamp     = w_out.time_stamp;
    assign o_body_length    = w_out.body_length;
    assign o_end_mark       = w_out.end_mark;

endmodule

[test/tb_length_prefixed_datagram_deframer_core.sv]
`timescale 1ns / 1ps
// Testbench for length_prefixed_datagram_deframer_core: byte-stream stimulus,
// in-bench deframing predictor and per-field result checking.
// Depends on lpdd_pkg and the deframer RTL.
module tb_length_prefixed_datagram_deframer_core;
    import lpdd_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [1:0]  o_kind;
    logic [7:0]  o_data_byte;
    logic        o_last_body_byte;
    logic [15:0] o_start_mark;
    logic [7:0]  o_message_type;
    logic [63:0] o_frame_id;
    logic [63:0] o_time_stamp;
    logic [31:0] o_body_length;
    logic [15:0] o_end_mark;

    length_prefixed_datagram_deframer_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_stall       (o_in_stall),
        .i_rx_byte        (i_rx_byte),
        .o_out_valid      (o_out_valid),
        .i_out_stall      (i_out_stall),
        .o_kind           (o_kind),
        .o_data_byte      (o_data_byte),
        .o_last_body_byte (o_last_body_byte),
        .o_start_mark     (o_start_mark),
        .o_message_type   (o_message_type),
        .o_frame_id       (o_frame_id),
        .o_time_stamp     (o_time_stamp),
        .o_body_length    (o_body_length),
        .o_end_mark       (o_end_mark)
    );

    // 4 ns clock
    always begin
        i_clk = 1'b1;
        #2;
        i_clk = 1'b0;
        #2;
    end

    t_result pending_results[$];   // predicted requests not yet seen on the output
    t_result result_want;
    int      failures   = 0;
    int      bytes_sent = 0;
    int      out_hold   = 0;       // cycles the result side still stalls
    bit      gaps_on    = 1'b0;    // random idling on both sides

    // Predictor state
    t_phase      rx_phase   = PH_START;
    logic [31:0] rx_count   = '0;
    logic [15:0] start_acc  = '0;
    logic [7:0]  type_acc   = '0;
    logic [63:0] id_acc     = '0;
    logic [63:0] stamp_acc  = '0;
    logic [31:0] length_acc = '0;
    logic [15:0] end_acc    = '0;

    // Count one byte of a field; move on once the field is complete
    function void count_byte(input logic [31:0] field_len, input t_phase nxt);
        rx_count = rx_count + 32'd1;
        if (rx_count >= field_len) begin
            rx_count = '0;
            rx_phase = nxt;
        end
    endfunction

    // Advance the deframer state by one byte; queue the request it produces
    function void deframe_byte(input logic [7:0] b);
        t_result r;
        logic    last;
        r = '0;
        case (rx_phase)
            PH_TYPE: begin
                type_acc = b;
                count_byte(TYPE_BYTES, PH_ID);
            end
            PH_ID: begin
                id_acc = {id_acc[55:0], b};
                count_byte(ID_BYTES, PH_REQID);
            end
            PH_REQID: begin
                r.kind      = KIND_REQID;
                r.data_byte = b;
                pending_results.push_back(r);
                count_byte(REQUEST_ID_BYTES, PH_STAMP);
            end
            PH_STAMP: begin
                stamp_acc = {stamp_acc[55:0], b};
                count_byte(STAMP_BYTES, PH_LEN);
            end
            PH_LEN: begin
                length_acc = {length_acc[23:0], b};
                count_byte(LEN_BYTES, PH_PREFIX);
            end
            PH_PREFIX: begin
                count_byte(PREFIX_BYTES, (length_acc == '0) ? PH_END : PH_BODY);
            end
            PH_BODY: begin
                last             = (rx_count == length_acc - 32'd1);
                r.kind           = KIND_BODY;
                r.data_byte      = b;
                r.last_body_byte = last;
                pending_results.push_back(r);
                if (last) begin
                    rx_count = '0;
                    rx_phase = PH_END;
                end else begin
                    rx_count = rx_count + 32'd1;
                end
            end
            PH_END: begin
                end_acc  = {end_acc[7:0], b};
                rx_count = rx_count + 32'd1;
                if (rx_count >= END_BYTES) begin
                    rx_count       = '0;
                    rx_phase       = PH_START;
                    r.kind         = KIND_FRAME;
                    r.start_mark   = start_acc;
                    r.message_type = type_acc;
                    r.frame_id     = id_acc;
                    r.time_stamp   = stamp_acc;
                    r.body_length  = length_acc;
                    r.end_mark     = end_acc;
                    pending_results.push_back(r);
                end
            end
            default: begin
                // start mark; stray phase codes fall back here
                if (rx_phase != PH_START) begin
                    rx_phase = PH_START;
                    rx_count = '0;
                end
                start_acc = {start_acc[7:0], b};
                count_byte(START_BYTES, PH_TYPE);
            end
        endcase
    endfunction

    function void check_field(input string name, input logic [63:0] want,
                              input logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            failures++;
        end
    endfunction

    // Result side: check each accepted request against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (pending_results.size() == 0) begin
                $error("unexpected result request, kind %0d", o_kind);
                failures++;
            end else begin
                result_want = pending_results.pop_front();
                check_field("kind", 64'(result_want.kind), 64'(o_kind));
                check_field("data_byte", 64'(result_want.data_byte),
                            64'(o_data_byte));
                check_field("last_body_byte", 64'(result_want.last_body_byte),
                            64'(o_last_body_byte));
                check_field("start_mark", 64'(result_want.start_mark),
                            64'(o_start_mark));
                check_field("message_type", 64'(result_want.message_type),
                            64'(o_message_type));
                check_field("frame_id", result_want.frame_id, o_frame_id);
                check_field("time_stamp", result_want.time_stamp, o_time_stamp);
                check_field("body_length", 64'(result_want.body_length),
                            64'(o_body_length));
                check_field("end_mark", 64'(result_want.end_mark),
                            64'(o_end_mark));
            end
            out_hold = gaps_on ? $urandom_range(0, 10) : 0;
        end
    end

    // Result side stall, drawn per accepted request
    always @(negedge i_clk) begin
        if (out_hold > 0) begin
            i_out_stall <= 1'b1;
            out_hold--;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    // Send one byte; entered and left at a falling edge with valid still high
    task send_byte(input logic [7:0] b);
        int gap;
        gap = gaps_on ? $urandom_range(0, 10) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        deframe_byte(b);
        bytes_sent++;
        @(negedge i_clk);
    endtask

    // Big-endian multi-byte field
    task send_field(input logic [63:0] v, input int nbytes);
        for (int i = nbytes - 1; i >= 0; i--) send_byte(v[8*i +: 8]);
    endtask

    task send_fill(input int n, input logic [7:0] fill, input bit rand_fill);
        for (int i = 0; i < n; i++)
            send_byte(rand_fill ? 8'($urandom_range(0, 255)) : fill);
    endtask

    task send_header(input logic [15:0] smark, input logic [7:0] mtype,
                     input logic [63:0] fid, input logic [63:0] tstamp,
                     input logic [31:0] blen, input logic [31:0] prefix,
                     input logic [7:0] fill, input bit rand_fill);
        send_field(64'(smark), 2);
        send_field(64'(mtype), 1);
        send_field(fid, 8);
        send_fill(REQUEST_ID_BYTES, fill, rand_fill);
        send_field(tstamp, 8);
        send_field(64'(blen), 4);
        send_field(64'(prefix), 4);
    endtask

    task send_frame(input logic [15:0] smark, input logic [7:0] mtype,
                    input logic [63:0] fid, input logic [63:0] tstamp,
                    input logic [31:0] blen, input logic [31:0] prefix,
                    input logic [15:0] emark, input logic [7:0] fill,
                    input bit rand_fill);
        send_header(smark, mtype, fid, tstamp, blen, prefix, fill, rand_fill);
        send_fill(blen, fill, rand_fill);
        send_field(64'(emark), 2);
    endtask

    task send_random_frame(input int max_len);
        send_frame(16'($urandom), 8'($urandom), {$urandom, $urandom},
                   {$urandom, $urandom}, $urandom_range(0, max_len), $urandom,
                   16'($urandom), 8'h00, 1'b1);
    endtask

    // Header all zero, empty body
    task test_all_zero_frame;
        gaps_on = 1'b0;
        send_frame('0, '0, '0, '0, 32'd0, '0, '0, 8'h00, 1'b0);
    endtask

    // Header all ones where allowed, empty body
    task test_all_ones_frame;
        gaps_on = 1'b1;
        send_frame('1, '1, '1, '1, 32'd0, '1, '1, 8'hFF, 1'b0);
    endtask

    // One- and two-byte bodies with alternating bit patterns
    task test_short_bodies;
        gaps_on = 1'b1;
        send_frame(16'hA5A5, 8'h5A, 64'hA5A5_A5A5_A5A5_A5A5, 64'h5A5A_5A5A_5A5A_5A5A,
                   32'd1, 32'hA5A5_A5A5, 16'h5A5A, 8'hA5, 1'b0);
        send_frame(16'h5A5A, 8'hA5, 64'h5A5A_5A5A_5A5A_5A5A, 64'hA5A5_A5A5_A5A5_A5A5,
                   32'd2, 32'h5A5A_5A5A, 16'hA5A5, 8'h5A, 1'b0);
    endtask

    // Frames back to back at full rate, no stalls
    task test_back_to_back;
        gaps_on = 1'b0;
        repeat (3) send_random_frame(8);
    endtask

    // Random frames, mostly short bodies, idling on and off per frame
    task test_random_stream;
        while (bytes_sent < 1800) begin
            gaps_on = ($urandom_range(0, 3) != 0);
            send_random_frame(($urandom_range(0, 7) == 0) ? 255 : 16);
        end
    endtask

    // Declared length far beyond the run; the stream never recovers, so last
    task test_huge_length;
        gaps_on = 1'b1;
        send_header(16'($urandom), 8'($urandom), {$urandom, $urandom},
                    {$urandom, $urandom}, 32'hFFFF_FFFF, $urandom, 8'h00, 1'b1);
        send_fill(48, 8'h00, 1'b1);
    endtask

    initial begin
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_rx_byte   = '0;
        i_out_stall = 1'b0;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_all_zero_frame();
        test_all_ones_frame();
        test_short_bodies();
        test_back_to_back();
        test_random_stream();
        test_huge_length();

        i_in_valid <= 1'b0;
        gaps_on = 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        if (failures == 0) begin
            $display("[length_prefixed_datagram_deframer_core] OK");
        end else begin
            $display("[length_prefixed_datagram_deframer_core] ERROR");
        end
        $finish;
    end

    // Run limit, several times the slowest correct run
    initial begin
        #3_000_000;
        $display("[length_prefixed_datagram_deframer_core] ERROR");
        $finish;
    end

endmodule

[filelist.f]
src/lpdd_pkg.sv
src/lpdd_parser.sv
src/lpdd_out_buf.sv
src/length_prefixed_datagram_deframer_core.sv
test/tb_length_prefixed_datagram_deframer_core.sv
